/* hdl/asks_pkg.sv */
// Shared types, constants and the keystream function of the alternating step
// keystream XOR unit. No dependencies.

package asks_pkg;

   localparam int DATA_W   = 8;
   localparam int LFSR_W   = 32;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;
   localparam int STEPS    = 8;

   localparam logic [LFSR_W-1:0] SEED_A_RESET = 32'h6132_3731;
   localparam logic [LFSR_W-1:0] SEED_B_RESET = 32'h3733_3037;
   localparam logic [LFSR_W-1:0] SEED_C_RESET = 32'h3238_6362;
   localparam logic [DATA_W-1:0] CRYPT_LENGTH_RESET = 8'd128;

   localparam logic [LFSR_W-1:0] POLY_A     = 32'hC000_0031;
   localparam logic [LFSR_W-1:0] FILL_B     = 32'hC000_0000;
   localparam logic [LFSR_W-1:0] POLY_B     = 32'h2000_0010;
   localparam logic [LFSR_W-1:0] MASK_B     = 32'h3FFF_FFFF;
   localparam logic [LFSR_W-1:0] FILL_C     = 32'hF000_0000;
   localparam logic [LFSR_W-1:0] POLY_C     = 32'h0800_0001;
   localparam logic [LFSR_W-1:0] MASK_C     = 32'h0FFF_FFFF;
   localparam logic [DATA_W-1:0] COUNT_MAX  = 8'd255;

   typedef enum logic [1:0] {
      REG_SEED_A       = 2'd0,
      REG_SEED_B       = 2'd1,
      REG_SEED_C       = 2'd2,
      REG_CRYPT_LENGTH = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [LFSR_W-1:0] seed_a;
      logic [LFSR_W-1:0] seed_b;
      logic [LFSR_W-1:0] seed_c;
      logic [DATA_W-1:0] crypt_length;
   } cfg_type;

   typedef struct packed {
      logic [LFSR_W-1:0] lfsr_a;
      logic [LFSR_W-1:0] lfsr_b;
      logic [LFSR_W-1:0] lfsr_c;
      logic [DATA_W-1:0] ks;
   } ks_result_type;

   // Runs the eight generator steps of one byte and returns the advanced
   // registers together with the keystream byte, first bit most significant.
   function automatic ks_result_type keystream(input logic [LFSR_W-1:0] a_in,
                                               input logic [LFSR_W-1:0] b_in,
                                               input logic [LFSR_W-1:0] c_in);
      logic [LFSR_W-1:0] a;
      logic [LFSR_W-1:0] b;
      logic [LFSR_W-1:0] c;
      logic              flag_b;
      logic              flag_c;
      logic              out_a;
      logic              out_b;
      logic              out_c;
      logic [DATA_W-1:0] ks;
      ks_result_type     res;
      a      = a_in;
      b      = b_in;
      c      = c_in;
      flag_b = 1'b1;
      flag_c = 1'b0;
      ks     = '0;
      for (int i = 0; i < STEPS; i++) begin
         out_a = a[0];
         a     = a >> 1;
         if (out_a) begin
            a      = a ^ POLY_A;
            out_b  = b[0];
            b      = b >> 1;
            b      = out_b ? ((b | FILL_B) ^ POLY_B) : (b & MASK_B);
            flag_b = out_b;
         end else begin
            out_c  = c[0];
            c      = c >> 1;
            c      = out_c ? ((c | FILL_C) ^ POLY_C) : (c & MASK_C);
            flag_c = out_c;
         end
         ks = {ks[DATA_W-2:0], flag_b ^ flag_c};
      end
      res.lfsr_a = a;
      res.lfsr_b = b;
      res.lfsr_c = c;
      res.ks     = ks;
      return res;
   endfunction

endpackage

/* hdl/asks_if.sv */
// Valid/ready channel interfaces for the request and response items.
// Depends on asks_pkg.

interface asks_req_if;
   import asks_pkg::*;
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_byte;
   logic              first_of_file;
   modport source (output valid, data_byte, first_of_file, input ready);
   modport sink (input valid, data_byte, first_of_file, output ready);
endinterface

interface asks_rsp_if;
   import asks_pkg::*;
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] out_byte;
   logic              was_crypted;
   modport source (output valid, out_byte, was_crypted, input ready);
   modport sink (input valid, out_byte, was_crypted, output ready);
endinterface

/* hdl/asks_csr.sv */
// APB-style register file holding the seeds and the crypt length.
// Depends on asks_pkg.

module asks_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [asks_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [asks_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [asks_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready,
   output asks_pkg::cfg_type             cfg
);
   import asks_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type idx;
   logic          wr_en;

   assign idx        = reg_index_type'(csr_paddr[CSR_AW-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_SEED_A:       cfg_in.seed_a = csr_pwdata;
            REG_SEED_B:       cfg_in.seed_b = csr_pwdata;
            REG_SEED_C:       cfg_in.seed_c = csr_pwdata;
            REG_CRYPT_LENGTH: cfg_in.crypt_length = csr_pwdata[DATA_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_SEED_A:       csr_prdata = cfg_ff.seed_a;
         REG_SEED_B:       csr_prdata = cfg_ff.seed_b;
         REG_SEED_C:       csr_prdata = cfg_ff.seed_c;
         REG_CRYPT_LENGTH: csr_prdata = {{(CSR_DW-DATA_W){1'b0}}, cfg_ff.crypt_length};
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.seed_a       <= SEED_A_RESET;
         cfg_ff.seed_b       <= SEED_B_RESET;
         cfg_ff.seed_c       <= SEED_C_RESET;
         cfg_ff.crypt_length <= CRYPT_LENGTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* hdl/asks_core.sv */
// Input register, keystream generator state and result register of the
// keystream XOR unit. Depends on asks_pkg and the channel interfaces.

module asks_core (
   input  logic              clock,
   input  logic              reset,
   input  asks_pkg::cfg_type cfg,
   asks_req_if.sink          req_ch,
   asks_rsp_if.source        rsp_ch
);
   import asks_pkg::*;

   logic              in_valid_ff;
   logic [DATA_W-1:0] in_data_ff;
   logic              in_first_ff;

   logic [LFSR_W-1:0] lfsr_a_ff, lfsr_b_ff, lfsr_c_ff;
   logic [LFSR_W-1:0] lfsr_a_in, lfsr_b_in, lfsr_c_in;
   logic [DATA_W-1:0] count_ff, count_in;

   logic              out_valid_ff;
   logic [DATA_W-1:0] out_byte_ff, out_byte_in;
   logic              out_crypted_ff, out_crypted_in;

   logic              out_free;
   logic              advance;
   logic [LFSR_W-1:0] cur_a, cur_b, cur_c;
   logic [DATA_W-1:0] cur_count;
   logic              do_crypt;
   ks_result_type     ks_res;

   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign advance      = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || out_free;

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.out_byte    = out_byte_ff;
   assign rsp_ch.was_crypted = out_crypted_ff;

   always_comb begin
      cur_a     = in_first_ff ? cfg.seed_a : lfsr_a_ff;
      cur_b     = in_first_ff ? cfg.seed_b : lfsr_b_ff;
      cur_c     = in_first_ff ? cfg.seed_c : lfsr_c_ff;
      cur_count = in_first_ff ? '0 : count_ff;
      do_crypt  = cur_count < cfg.crypt_length;
      ks_res    = keystream(cur_a, cur_b, cur_c);

      lfsr_a_in      = do_crypt ? ks_res.lfsr_a : cur_a;
      lfsr_b_in      = do_crypt ? ks_res.lfsr_b : cur_b;
      lfsr_c_in      = do_crypt ? ks_res.lfsr_c : cur_c;
      count_in       = (cur_count == COUNT_MAX) ? cur_count : cur_count + 1'b1;
      out_byte_in    = do_crypt ? (in_data_ff ^ ks_res.ks) : in_data_ff;
      out_crypted_in = do_crypt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         lfsr_a_ff    <= SEED_A_RESET;
         lfsr_b_ff    <= SEED_B_RESET;
         lfsr_c_ff    <= SEED_C_RESET;
         count_ff     <= '0;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            lfsr_a_ff <= lfsr_a_in;
            lfsr_b_ff <= lfsr_b_in;
            lfsr_c_ff <= lfsr_c_in;
            count_ff  <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_data_ff  <= req_ch.data_byte;
         in_first_ff <= req_ch.first_of_file;
      end
      if (advance) begin
         out_byte_ff    <= out_byte_in;
         out_crypted_ff <= out_crypted_in;
      end
   end

endmodule

/* hdl/alternating_step_keystream_xor_unit.sv */
// Top level of the alternating step keystream XOR unit.
// Depends on asks_pkg, the channel interfaces, asks_csr and asks_core.

// Usage:
// Each request item carries one data byte and a first-of-file flag; each
// produces exactly one response item with the output byte and a flag that
// tells whether keystream was applied. A first-of-file item reloads the three
// generator registers from the seed registers and restarts the byte count.
// Only the first crypt_length bytes of a file are XORed; later bytes pass
// through unchanged and leave the generator as it is.
// A request item accepted into the input register is registered again in the
// response register before it is shown as a response item.
// Throughput is one item per cycle while the receiver does not stall: the
// eight generator steps of a byte are evaluated in the single logic stage
// between the input register and the response register.
// When the receiver stalls, the response register holds its item and the
// input register can still take one more item before the request side stalls.
// Reset empties both registers, restores the register file to its default
// seeds and crypt length, and loads the generator with the default seeds.
// Seed and length registers must be written by the user over the APB-style
// port while idle, which the block does not enforce; seed writes take effect at the next first-of-file item.

module alternating_step_keystream_xor_unit (
   input  logic                        clock,
   input  logic                        reset,
   asks_req_if.sink                    req_ch,
   asks_rsp_if.source                  rsp_ch,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [asks_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [asks_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [asks_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready
);
   import asks_pkg::*;

   cfg_type cfg;

   asks_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   asks_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

endmodule

/* hdl/asks_checker.sv */
// Port-level checks for the alternating step keystream XOR unit, bound to
// the top level. Depends on asks_pkg.

module asks_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [asks_pkg::DATA_W-1:0] rsp_out_byte,
   input logic                        rsp_was_crypted
);
   import asks_pkg::*;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("Response item dropped while stalled.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_byte) && $stable(rsp_was_crypted))
      else $error("Response payload changed while stalled.");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Response valid after reset.");

   assert property (@(posedge clock)
      !rsp_valid |-> req_ready)
      else $error("Request side stalled with an empty response register.");

endmodule

bind alternating_step_keystream_xor_unit asks_checker u_asks_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_out_byte    (rsp_ch.out_byte),
   .rsp_was_crypted (rsp_ch.was_crypted)
);

/* test/tb.sv */
// Self-checking testbench for the alternating step keystream XOR unit.
// It predicts every response byte from its own model of the three generators.
// Depends on asks_pkg, the channel interfaces and the unit's RTL.

module tb;
   import asks_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int LONG_STALL    = 64;
   localparam int ERR_PRINT_MAX = 100;
   localparam int HALF_PHASE    = 44;
   localparam int PHASES        = 8;

   typedef struct packed {
      logic [DATA_W-1:0] data_byte;
      logic              first_of_file;
   } plain_item_type;

   typedef struct packed {
      logic [DATA_W-1:0] out_byte;
      logic              was_crypted;
   } crypt_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   asks_req_if req_ch();
   asks_rsp_if rsp_ch();

   alternating_step_keystream_xor_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   logic [LFSR_W-1:0] cfg_seed_a;
   logic [LFSR_W-1:0] cfg_seed_b;
   logic [LFSR_W-1:0] cfg_seed_c;
   logic [DATA_W-1:0] cfg_crypt_len;
   logic [LFSR_W-1:0] gen_a;
   logic [LFSR_W-1:0] gen_b;
   logic [LFSR_W-1:0] gen_c;
   logic [DATA_W-1:0] file_pos;

   plain_item_type bytes_to_send[$];
   crypt_item_type expected_out[$];

   int errors       = 0;
   int cycles       = 0;
   int offered_n    = 0;
   int accepted_n   = 0;
   int stall_asked  = 0;
   int stall_served = 0;
   int tx_gap       = 0;
   int rx_gap       = 0;
   bit idle_on      = 1'b1;

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      errors++;
      if (errors <= ERR_PRINT_MAX) begin
         $display("MISMATCH at cycle %0d: %s", cycles, what);
      end
   endtask

   // Eight alternating steps: A always shifts, its output bit picks B or C.
   task automatic step_generators(output logic [DATA_W-1:0] key);
      logic fb;
      logic fc;
      fb  = 1'b1;
      fc  = 1'b0;
      key = '0;
      repeat (STEPS) begin
         if (gen_a[0]) begin
            gen_a = (gen_a >> 1) ^ POLY_A;
            fb    = gen_b[0];
            gen_b = fb ? ({2'b11, gen_b[30:1]} ^ POLY_B) : {2'b00, gen_b[30:1]};
         end else begin
            gen_a = gen_a >> 1;
            fc    = gen_c[0];
            gen_c = fc ? ({4'hF, gen_c[28:1]} ^ POLY_C) : {4'h0, gen_c[28:1]};
         end
         key = {key[DATA_W-2:0], fb ^ fc};
      end
   endtask

   task automatic crypt_predict(input plain_item_type it);
      logic [DATA_W-1:0] key;
      crypt_item_type    res;
      if (it.first_of_file) begin
         gen_a    = cfg_seed_a;
         gen_b    = cfg_seed_b;
         gen_c    = cfg_seed_c;
         file_pos = '0;
      end
      if (file_pos < cfg_crypt_len) begin
         step_generators(key);
         res.out_byte    = it.data_byte ^ key;
         res.was_crypted = 1'b1;
      end else begin
         res.out_byte    = it.data_byte;
         res.was_crypted = 1'b0;
      end
      if (file_pos != COUNT_MAX) begin
         file_pos++;
      end
      expected_out.push_back(res);
   endtask

   always @(posedge clock) begin : monitor
      crypt_item_type want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            crypt_predict('{req_ch.data_byte, req_ch.first_of_file});
            void'(bytes_to_send.pop_front());
            accepted_n++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_out.size() == 0) begin
               report_mismatch("response item with no request outstanding");
            end else begin
               want = expected_out.pop_front();
               if (rsp_ch.out_byte !== want.out_byte) begin
                  report_mismatch($sformatf("out_byte %h, expected %h",
                                            rsp_ch.out_byte, want.out_byte));
               end
               if (rsp_ch.was_crypted !== want.was_crypted) begin
                  report_mismatch($sformatf("was_crypted %b, expected %b",
                                            rsp_ch.was_crypted, want.was_crypted));
               end
            end
         end
      end
   end

   always @(negedge clock) begin : sender
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (offered_n == accepted_n) begin
         if (tx_gap > 0) begin
            tx_gap--;
            req_ch.valid <= 1'b0;
         end else if (bytes_to_send.size() == 0) begin
            req_ch.valid <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            tx_gap = $urandom_range(0, 17);
            req_ch.valid <= 1'b0;
         end else begin
            req_ch.valid         <= 1'b1;
            req_ch.data_byte     <= bytes_to_send[0].data_byte;
            req_ch.first_of_file <= bytes_to_send[0].first_of_file;
            offered_n++;
         end
      end
   end

   always @(negedge clock) begin : receiver
      if (stall_served != stall_asked) begin
         stall_served++;
         rx_gap = LONG_STALL;
      end
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (rx_gap > 0) begin
         rx_gap--;
         rsp_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         rx_gap = $urandom_range(0, 17);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   task automatic queue_plain(input logic [DATA_W-1:0] d, input logic f);
      bytes_to_send.push_back('{d, f});
   endtask

   task automatic wait_drained();
      while (bytes_to_send.size() != 0 || expected_out.size() != 0 ||
             offered_n != accepted_n) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input reg_index_type idx,
                             input logic [CSR_DW-1:0] wdata,
                             output logic [CSR_DW-1:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_reg(input reg_index_type idx, input logic [CSR_DW-1:0] value);
      logic [CSR_DW-1:0] rd;
      logic [CSR_DW-1:0] mask;
      csr_access(1'b1, idx, value, rd);
      case (idx)
         REG_SEED_A:       cfg_seed_a    = value;
         REG_SEED_B:       cfg_seed_b    = value;
         REG_SEED_C:       cfg_seed_c    = value;
         REG_CRYPT_LENGTH: cfg_crypt_len = value[DATA_W-1:0];
         default: ;
      endcase
      mask = (idx == REG_CRYPT_LENGTH) ? CSR_DW'({DATA_W{1'b1}}) : '1;
      csr_access(1'b0, idx, '0, rd);
      if ((rd & mask) !== (value & mask)) begin
         report_mismatch($sformatf("register %s reads %h, expected %h",
                                   idx.name(), rd & mask, value & mask));
      end
   endtask

   function automatic logic [LFSR_W-1:0] pick_seed();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] pick_length();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return 8'd1;
         2:       return COUNT_MAX;
         3:       return DATA_W'($urandom_range(2, 16));
         default: return DATA_W'($urandom_range(0, 255));
      endcase
   endfunction

   initial begin : stimulus
      int len;
      int sent;
      req_ch.valid         = 1'b0;
      req_ch.data_byte     = '0;
      req_ch.first_of_file = 1'b0;
      rsp_ch.ready         = 1'b0;
      csr_psel             = 1'b0;
      csr_penable          = 1'b0;
      csr_pwrite           = 1'b0;
      csr_paddr            = '0;
      csr_pwdata           = '0;
      cfg_seed_a           = SEED_A_RESET;
      cfg_seed_b           = SEED_B_RESET;
      cfg_seed_c           = SEED_C_RESET;
      cfg_crypt_len        = CRYPT_LENGTH_RESET;
      gen_a                = SEED_A_RESET;
      gen_b                = SEED_B_RESET;
      gen_c                = SEED_C_RESET;
      file_pos             = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // The first bytes come before any start of file and use the reset seeds.
      queue_plain(8'h00, 1'b0);
      queue_plain(8'hFF, 1'b0);
      queue_plain(8'h55, 1'b0);
      queue_plain(8'hAA, 1'b0);
      queue_plain(8'h80, 1'b1);
      queue_plain(8'h01, 1'b0);
      wait_drained();
      set_reg(REG_CRYPT_LENGTH, 32'd2);
      queue_plain(8'h3C, 1'b1);
      queue_plain(8'hC3, 1'b0);
      queue_plain(8'hFF, 1'b0);
      queue_plain(8'h00, 1'b0);
      wait_drained();
      set_reg(REG_CRYPT_LENGTH, 32'd0);
      queue_plain(8'h5A, 1'b1);
      queue_plain(8'hA5, 1'b0);
      wait_drained();
      // New seeds must not take effect until the next start of file.
      set_reg(REG_CRYPT_LENGTH, 32'd255);
      set_reg(REG_SEED_A, 32'h0000_0000);
      set_reg(REG_SEED_B, 32'h0000_0000);
      set_reg(REG_SEED_C, 32'h0000_0000);
      queue_plain(8'h11, 1'b0);
      queue_plain(8'h22, 1'b1);
      queue_plain(8'h33, 1'b0);
      queue_plain(8'h44, 1'b0);
      wait_drained();
      set_reg(REG_SEED_A, 32'hFFFF_FFFF);
      set_reg(REG_SEED_B, 32'hFFFF_FFFF);
      set_reg(REG_SEED_C, 32'hFFFF_FFFF);
      queue_plain(8'hEE, 1'b0);
      queue_plain(8'h77, 1'b1);
      queue_plain(8'h88, 1'b0);
      wait_drained();
      set_reg(REG_CRYPT_LENGTH, 32'd1);
      queue_plain(8'h0F, 1'b1);
      queue_plain(8'hF0, 1'b0);
      wait_drained();

      for (int ph = 0; ph < PHASES; ph++) begin
         idle_on = !(ph == 3 || ph == PHASES - 1);
         set_reg(REG_SEED_A, pick_seed());
         set_reg(REG_SEED_B, pick_seed());
         set_reg(REG_SEED_C, pick_seed());
         set_reg(REG_CRYPT_LENGTH, (ph == 1) ? CSR_DW'(COUNT_MAX) : CSR_DW'(pick_length()));
         for (int half = 0; half < 2; half++) begin
            sent = 0;
            while (sent < HALF_PHASE) begin
               len = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
               if (ph == 1 && half == 0 && sent == 0) begin
                  len = 280;
               end
               // Long files run unbroken so that the byte count saturates.
               for (int k = 0; k < len; k++) begin
                  queue_plain(DATA_W'($urandom_range(0, 255)),
                              k == 0 || (len < 100 && $urandom_range(0, 31) == 0));
               end
               sent += len;
            end
            if (ph == 2 && half == 0) begin
               stall_asked++;
            end
            wait_drained();
         end
      end

      wait_drained();
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
